@@ sv/rmea_pkg.sv @@
package rmea_pkg;

   localparam int SQRT_STEPS    = 15;
   localparam int SQRT_STAGES   = 8;
   localparam int CORDIC_STEPS  = 16;
   localparam int CORDIC_STAGES = 8;
   localparam int HALF_PI       = 1647099;
   localparam int ANGLE_LIMIT   = 25736;

   typedef enum logic [3:0] {
      SEQ_ZXZ = 4'd0,
      SEQ_XYX = 4'd1,
      SEQ_YZY = 4'd2,
      SEQ_ZYZ = 4'd3,
      SEQ_XZX = 4'd4,
      SEQ_YXY = 4'd5,
      SEQ_XZY = 4'd6,
      SEQ_XYZ = 4'd7,
      SEQ_YXZ = 4'd8,
      SEQ_YZX = 4'd9,
      SEQ_ZYX = 4'd10,
      SEQ_ZXY = 4'd11
   } seq_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic [1:0] a0;
      logic [1:0] a1;
      logic [1:0] a2;
   } axes_type;

   typedef struct packed {
      logic     proper;
      logic     neg;
      axes_type axes;
      logic     bad;
   } meta_type;

   typedef struct packed {
      logic signed [16:0] y1;
      logic signed [16:0] x1;
      logic signed [16:0] y3;
      logic signed [16:0] x3;
      logic signed [15:0] c;
   } ops_type;

   typedef struct packed {
      logic [29:0] rem;
      logic [29:0] res;
   } root_type;

   typedef struct packed {
      logic signed [27:0] x;
      logic signed [27:0] y;
      logic signed [23:0] z;
   } vec_type;

   function automatic logic signed [23:0] atan_entry(input int i);
      logic signed [23:0] t;
      case (i)
         0:       t = 24'sd823550;
         1:       t = 24'sd486170;
         2:       t = 24'sd256879;
         3:       t = 24'sd130396;
         4:       t = 24'sd65451;
         5:       t = 24'sd32757;
         6:       t = 24'sd16383;
         7:       t = 24'sd8192;
         8:       t = 24'sd4096;
         9:       t = 24'sd2048;
         10:      t = 24'sd1024;
         11:      t = 24'sd512;
         12:      t = 24'sd256;
         13:      t = 24'sd128;
         14:      t = 24'sd64;
         default: t = 24'sd32;
      endcase
      return t;
   endfunction

   // One digit of the restoring square root; step j tests bit 28 - 2j.
   function automatic root_type sqrt_step(input root_type s, input int j);
      root_type    r;
      logic [29:0] bitv;
      logic [29:0] trial;
      bitv  = 30'd1 << (28 - 2 * j);
      trial = s.res + bitv;
      if (s.rem >= trial) begin
         r.rem = s.rem - trial;
         r.res = (s.res >> 1) + bitv;
      end else begin
         r.rem = s.rem;
         r.res = s.res >> 1;
      end
      return r;
   endfunction

   function automatic vec_type cordic_step(input vec_type v, input int i);
      vec_type            r;
      logic signed [27:0] x;
      logic signed [27:0] y;
      logic signed [27:0] xs;
      logic signed [27:0] ys;
      x  = v.x;
      y  = v.y;
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
         r.x = x + ys;
         r.y = y - xs;
         r.z = v.z + atan_entry(i);
      end else begin
         r.x = x - ys;
         r.y = y + xs;
         r.z = v.z - atan_entry(i);
      end
      return r;
   endfunction

   // Inertial frames reverse the order of the Tait-Bryan axes only.
   function automatic axes_type axis_lookup(input logic [3:0] f, input logic space);
      axes_type a;
      axes_type b;
      a = '0;
      unique case (f)
         SEQ_ZXZ: a = {AXIS_Z, AXIS_X, AXIS_Z};
         SEQ_XYX: a = {AXIS_X, AXIS_Y, AXIS_X};
         SEQ_YZY: a = {AXIS_Y, AXIS_Z, AXIS_Y};
         SEQ_ZYZ: a = {AXIS_Z, AXIS_Y, AXIS_Z};
         SEQ_XZX: a = {AXIS_X, AXIS_Z, AXIS_X};
         SEQ_YXY: a = {AXIS_Y, AXIS_X, AXIS_Y};
         SEQ_XZY: a = {AXIS_X, AXIS_Z, AXIS_Y};
         SEQ_XYZ: a = {AXIS_X, AXIS_Y, AXIS_Z};
         SEQ_YXZ: a = {AXIS_Y, AXIS_X, AXIS_Z};
         SEQ_YZX: a = {AXIS_Y, AXIS_Z, AXIS_X};
         SEQ_ZYX: a = {AXIS_Z, AXIS_Y, AXIS_X};
         SEQ_ZXY: a = {AXIS_Z, AXIS_X, AXIS_Y};
         default: a = '0;
      endcase
      b = a;
      if (space && f >= SEQ_XZY && f <= SEQ_ZXY) begin
         b.a0 = a.a2;
         b.a2 = a.a0;
      end
      return b;
   endfunction

endpackage

@@ sv/rmea_isqrt.sv @@
module rmea_isqrt (
   input  logic                               clock,
   input  logic [rmea_pkg::SQRT_STAGES-1:0]   en,
   input  logic [28:0]                        d,
   output logic [14:0]                        root
);

   rmea_pkg::root_type st_ff [rmea_pkg::SQRT_STAGES];

   for (genvar s = 0; s < rmea_pkg::SQRT_STAGES; s++) begin : g_stage
      rmea_pkg::root_type st_prev;
      rmea_pkg::root_type st_in;

      if (s == 0) begin : g_head
         assign st_prev = {1'b0, d, 30'd0};
      end else begin : g_link
         assign st_prev = st_ff[s-1];
      end

      always_comb begin
         st_in = st_prev;
         for (int j = 0; j < 2; j++) begin
            if (2 * s + j < rmea_pkg::SQRT_STEPS) begin
               st_in = rmea_pkg::sqrt_step(st_in, 2 * s + j);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            st_ff[s] <= st_in;
         end
      end
   end

   assign root = st_ff[rmea_pkg::SQRT_STAGES-1].res[14:0];

endmodule

@@ sv/rmea_atan2.sv @@
module rmea_atan2 (
   input  logic                               clock,
   input  logic [rmea_pkg::CORDIC_STAGES:0]   en,
   input  logic signed [16:0]                 y_in,
   input  logic signed [16:0]                 x_in,
   output logic signed [15:0]                 angle
);

   rmea_pkg::vec_type vec_ff  [rmea_pkg::CORDIC_STAGES+1];
   logic              zero_ff [rmea_pkg::CORDIC_STAGES+1];

   rmea_pkg::vec_type  pre_in;
   logic signed [27:0] xw;
   logic signed [27:0] yw;

   // Scale by 256 and turn a vector in the left half plane by a quarter turn.
   always_comb begin
      xw = 28'(x_in) <<< 8;
      yw = 28'(y_in) <<< 8;
      if (xw < 0) begin
         if (yw >= 0) begin
            pre_in.x = yw;
            pre_in.y = -xw;
            pre_in.z = 24'(rmea_pkg::HALF_PI);
         end else begin
            pre_in.x = -yw;
            pre_in.y = xw;
            pre_in.z = -24'(rmea_pkg::HALF_PI);
         end
      end else begin
         pre_in.x = xw;
         pre_in.y = yw;
         pre_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         vec_ff[0]  <= pre_in;
         zero_ff[0] <= (x_in == 0) && (y_in == 0);
      end
   end

   for (genvar s = 1; s <= rmea_pkg::CORDIC_STAGES; s++) begin : g_stage
      rmea_pkg::vec_type vec_in;

      always_comb begin
         vec_in = vec_ff[s-1];
         for (int j = 0; j < 2; j++) begin
            vec_in = rmea_pkg::cordic_step(vec_in, 2 * (s - 1) + j);
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            vec_ff[s]  <= vec_in;
            zero_ff[s] <= zero_ff[s-1];
         end
      end
   end

   logic signed [23:0] zr;
   logic signed [16:0] r;

   always_comb begin
      zr = vec_ff[rmea_pkg::CORDIC_STAGES].z + 24'sd64;
      r  = 17'(zr >>> 7);
      if (zero_ff[rmea_pkg::CORDIC_STAGES]) begin
         angle = '0;
      end else if (r > 17'(rmea_pkg::ANGLE_LIMIT)) begin
         angle = 16'(rmea_pkg::ANGLE_LIMIT);
      end else if (r < -17'(rmea_pkg::ANGLE_LIMIT)) begin
         angle = -16'(rmea_pkg::ANGLE_LIMIT);
      end else begin
         angle = r[15:0];
      end
   end

endmodule

@@ sv/rotation_matrix_to_euler_angles.sv @@
// Rotation matrix to Euler angles. Each beat carries a 3x3 Q1.14 matrix, a
// sequence code and a rotation space; the result beat carries three Q3.13
// angles, the three axis codes and a flag for an unknown sequence code. The
// block takes one beat per cycle while req_stall is low; each result beat
// passes twenty register stages: one input stage, one stage that picks the
// matrix terms and forms 1 - c*c, eight stages of square root at two digits
// each (one in the last), and three parallel CORDIC lanes of nine stages (a
// quarter turn then two rotations per stage) that a final output stage merges.
// Empty stages fill up while the output is stalled, so input beats keep
// entering until the pipeline is full.
module rotation_matrix_to_euler_angles (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_func,
   input  logic               req_rotation_space,
   input  logic signed [15:0] req_m_r0c0,
   input  logic signed [15:0] req_m_r0c1,
   input  logic signed [15:0] req_m_r0c2,
   input  logic signed [15:0] req_m_r1c0,
   input  logic signed [15:0] req_m_r1c1,
   input  logic signed [15:0] req_m_r1c2,
   input  logic signed [15:0] req_m_r2c0,
   input  logic signed [15:0] req_m_r2c1,
   input  logic signed [15:0] req_m_r2c2,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_first_angle,
   output logic signed [15:0] rsp_second_angle,
   output logic signed [15:0] rsp_third_angle,
   output logic [1:0]         rsp_first_axis,
   output logic [1:0]         rsp_second_axis,
   output logic [1:0]         rsp_third_axis,
   output logic               rsp_bad_sequence
);

   localparam int SQ0   = 2;
   localparam int AT0   = SQ0 + rmea_pkg::SQRT_STAGES;
   localparam int OUTS  = AT0 + rmea_pkg::CORDIC_STAGES + 1;
   localparam int DEPTH = OUTS + 1;

   logic [DEPTH-1:0] v_ff;
   logic [DEPTH-1:0] en;

   // A stage may load unless it and every stage after it hold a beat and
   // the output is stalled.
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         en[k] = !(rsp_stall && ((v_ff | ((DEPTH'(1) << k) - DEPTH'(1))) == '1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < DEPTH; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[DEPTH-1];

   // Input stage.
   logic [3:0]         func_ff;
   logic               space_ff;
   logic signed [15:0] m_ff [9];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         func_ff  <= req_func;
         space_ff <= req_rotation_space;
         m_ff[0]  <= req_m_r0c0;
         m_ff[1]  <= req_m_r0c1;
         m_ff[2]  <= req_m_r0c2;
         m_ff[3]  <= req_m_r1c0;
         m_ff[4]  <= req_m_r1c1;
         m_ff[5]  <= req_m_r1c2;
         m_ff[6]  <= req_m_r2c0;
         m_ff[7]  <= req_m_r2c1;
         m_ff[8]  <= req_m_r2c2;
      end
   end

   function automatic logic signed [16:0] pos(input logic signed [15:0] a);
      return 17'(a);
   endfunction

   function automatic logic signed [16:0] ngt(input logic signed [15:0] a);
      return -17'(a);
   endfunction

   // Term selection and the argument of the square root.
   rmea_pkg::ops_type  ops_in;
   rmea_pkg::meta_type meta_in;
   logic signed [31:0] sq;
   logic signed [32:0] diff;
   logic [28:0]        d_in;

   always_comb begin
      ops_in         = '0;
      meta_in        = '0;
      meta_in.axes   = rmea_pkg::axis_lookup(func_ff, space_ff);
      case (func_ff)
         rmea_pkg::SEQ_ZXZ: begin
            ops_in = {pos(m_ff[2]), ngt(m_ff[5]), pos(m_ff[6]), pos(m_ff[7]), m_ff[8]};
            meta_in.proper = 1'b1;
         end
         rmea_pkg::SEQ_XYX: begin
            ops_in = {pos(m_ff[3]), ngt(m_ff[6]), pos(m_ff[1]), pos(m_ff[2]), m_ff[0]};
            meta_in.proper = 1'b1;
         end
         rmea_pkg::SEQ_YZY: begin
            ops_in = {pos(m_ff[7]), ngt(m_ff[1]), pos(m_ff[5]), pos(m_ff[3]), m_ff[4]};
            meta_in.proper = 1'b1;
         end
         rmea_pkg::SEQ_ZYZ: begin
            ops_in = {pos(m_ff[5]), pos(m_ff[2]), pos(m_ff[7]), ngt(m_ff[6]), m_ff[8]};
            meta_in.proper = 1'b1;
         end
         rmea_pkg::SEQ_XZX: begin
            ops_in = {pos(m_ff[6]), pos(m_ff[3]), pos(m_ff[2]), ngt(m_ff[1]), m_ff[0]};
            meta_in.proper = 1'b1;
         end
         rmea_pkg::SEQ_YXY: begin
            ops_in = {pos(m_ff[1]), pos(m_ff[7]), pos(m_ff[3]), ngt(m_ff[5]), m_ff[4]};
            meta_in.proper = 1'b1;
         end
         rmea_pkg::SEQ_XZY: begin
            ops_in = {pos(m_ff[7]), pos(m_ff[4]), pos(m_ff[2]), pos(m_ff[0]), m_ff[1]};
            meta_in.neg = 1'b1;
         end
         rmea_pkg::SEQ_XYZ: begin
            ops_in = {ngt(m_ff[5]), pos(m_ff[8]), ngt(m_ff[1]), pos(m_ff[0]), m_ff[2]};
         end
         rmea_pkg::SEQ_YXZ: begin
            ops_in = {pos(m_ff[2]), pos(m_ff[8]), pos(m_ff[3]), pos(m_ff[4]), m_ff[5]};
            meta_in.neg = 1'b1;
         end
         rmea_pkg::SEQ_YZX: begin
            ops_in = {ngt(m_ff[6]), pos(m_ff[0]), ngt(m_ff[5]), pos(m_ff[4]), m_ff[3]};
         end
         rmea_pkg::SEQ_ZYX: begin
            ops_in = {pos(m_ff[3]), pos(m_ff[0]), pos(m_ff[7]), pos(m_ff[8]), m_ff[6]};
            meta_in.neg = 1'b1;
         end
         rmea_pkg::SEQ_ZXY: begin
            ops_in = {ngt(m_ff[1]), pos(m_ff[4]), ngt(m_ff[6]), pos(m_ff[8]), m_ff[7]};
         end
         default: begin
            meta_in.bad = 1'b1;
         end
      endcase
      sq   = ops_in.c * ops_in.c;
      diff = 33'sd268435456 - 33'(sq);
      d_in = (diff < 0) ? '0 : diff[28:0];
   end

   rmea_pkg::ops_type  ops_ff  [1:AT0-1];
   rmea_pkg::meta_type meta_ff [1:OUTS-1];
   logic [28:0]        d_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         ops_ff[1]  <= ops_in;
         meta_ff[1] <= meta_in;
         d_ff       <= d_in;
      end
      for (int k = 2; k < OUTS; k++) begin
         if (en[k]) begin
            meta_ff[k] <= meta_ff[k-1];
            if (k < AT0) begin
               ops_ff[k] <= ops_ff[k-1];
            end
         end
      end
   end

   logic [14:0] root;

   rmea_isqrt u_isqrt (
      .clock (clock),
      .en    (en[AT0-1:SQ0]),
      .d     (d_ff),
      .root  (root)
   );

   // Middle-angle operands: proper sequences take (root, c), Tait-Bryan (+-c, root).
   logic signed [16:0] mid_y;
   logic signed [16:0] mid_x;

   always_comb begin
      if (meta_ff[AT0-1].proper) begin
         mid_y = 17'({2'b00, root});
         mid_x = pos(ops_ff[AT0-1].c);
      end else begin
         mid_y = meta_ff[AT0-1].neg ? ngt(ops_ff[AT0-1].c) : pos(ops_ff[AT0-1].c);
         mid_x = 17'({2'b00, root});
      end
   end

   logic signed [15:0] ang1;
   logic signed [15:0] ang2;
   logic signed [15:0] ang3;

   rmea_atan2 u_lane1 (
      .clock (clock),
      .en    (en[OUTS-1:AT0]),
      .y_in  (ops_ff[AT0-1].y1),
      .x_in  (ops_ff[AT0-1].x1),
      .angle (ang1)
   );

   rmea_atan2 u_lane2 (
      .clock (clock),
      .en    (en[OUTS-1:AT0]),
      .y_in  (mid_y),
      .x_in  (mid_x),
      .angle (ang2)
   );

   rmea_atan2 u_lane3 (
      .clock (clock),
      .en    (en[OUTS-1:AT0]),
      .y_in  (ops_ff[AT0-1].y3),
      .x_in  (ops_ff[AT0-1].x3),
      .angle (ang3)
   );

   // Merge stage and output register.
   logic signed [15:0] first_angle_ff;
   logic signed [15:0] second_angle_ff;
   logic signed [15:0] third_angle_ff;
   rmea_pkg::axes_type axes_ff;
   logic               bad_ff;

   always_ff @(posedge clock) begin
      if (en[OUTS]) begin
         first_angle_ff  <= meta_ff[OUTS-1].bad ? '0 : ang1;
         second_angle_ff <= meta_ff[OUTS-1].bad ? '0 : ang2;
         third_angle_ff  <= meta_ff[OUTS-1].bad ? '0 : ang3;
         axes_ff         <= meta_ff[OUTS-1].axes;
         bad_ff          <= meta_ff[OUTS-1].bad;
      end
   end

   assign rsp_first_angle  = first_angle_ff;
   assign rsp_second_angle = second_angle_ff;
   assign rsp_third_angle  = third_angle_ff;
   assign rsp_first_axis   = axes_ff.a0;
   assign rsp_second_axis  = axes_ff.a1;
   assign rsp_third_axis   = axes_ff.a2;
   assign rsp_bad_sequence = bad_ff;

endmodule

@@ sv/rmea_checker.sv @@
module rmea_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_first_angle,
   input logic signed [15:0] rsp_second_angle,
   input logic signed [15:0] rsp_third_angle,
   input logic [1:0]         rsp_first_axis,
   input logic [1:0]         rsp_second_axis,
   input logic [1:0]         rsp_third_axis,
   input logic               rsp_bad_sequence
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_first_angle)
         && $stable(rsp_third_axis))
      else $error("result beat changed while stalled");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_sequence |-> rsp_first_angle == 0 && rsp_second_angle == 0
         && rsp_third_angle == 0 && rsp_first_axis == 0 && rsp_second_axis == 0
         && rsp_third_axis == 0)
      else $error("unknown sequence with nonzero fields");

   a_axes_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_sequence |-> rsp_first_axis != 2'd3 && rsp_second_axis != 2'd3
         && rsp_third_axis != 2'd3 && rsp_first_axis != rsp_second_axis
         && rsp_second_axis != rsp_third_axis)
      else $error("axis codes do not form a sequence");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_first_angle <= 16'sd25736 && rsp_first_angle >= -16'sd25736
         && rsp_second_angle <= 16'sd25736 && rsp_second_angle >= -16'sd25736
         && rsp_third_angle <= 16'sd25736 && rsp_third_angle >= -16'sd25736)
      else $error("angle out of range");

   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output can move");

endmodule

bind rotation_matrix_to_euler_angles rmea_checker u_rmea_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_first_angle  (rsp_first_angle),
   .rsp_second_angle (rsp_second_angle),
   .rsp_third_angle  (rsp_third_angle),
   .rsp_first_axis   (rsp_first_axis),
   .rsp_second_axis  (rsp_second_axis),
   .rsp_third_axis   (rsp_third_axis),
   .rsp_bad_sequence (rsp_bad_sequence)
);
